/* hdl/grbs_pkg.sv */
// grbs_pkg: shared types, constants and the rate saturation helper for the
// gyro rate bias smoother. No dependencies; every other file imports it.
`default_nettype none

package grbs_pkg;

   // field and datapath widths
   localparam int AXES        = 3;
   localparam int RAW_W       = 16;
   localparam int WORD_W      = RAW_W + 1;
   localparam int RATE_W      = 28;
   localparam int SCALE_W     = 24;
   localparam int PROD_W      = WORD_W + SCALE_W;
   localparam int WIDE_W      = 48;
   localparam int SUM_W       = 44;
   localparam int COUNT_W     = 16;
   localparam int RING_TAPS   = 4;
   localparam int TAP_N       = RING_TAPS - 1;
   localparam int SMSUM_W     = 33;
   localparam int HALF_W      = 31;
   localparam int RECIP_W     = 31;
   localparam int RECIP_P_W   = HALF_W + RECIP_W;
   localparam int DIV_NUM_W   = SUM_W + 1;
   localparam int DIV_DEN_W   = COUNT_W + 1;
   localparam int DIV_CNT_W   = 6;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_TDATA_W = 3 * RAW_W;
   localparam int RSP_TDATA_W = 88;

   // pi / (180 * 14.375) in unsigned Q32, held signed for the multiplier
   localparam logic signed [SCALE_W-1:0] SCALE_Q32 = 24'sd5214701;
   // ceil(2^32 / 3) for the divide by three
   localparam logic [RECIP_W-1:0] RECIP_THIRD = 31'h55555556;
   // 6 * 2^28 keeps the smoothing sum positive, plus 3 for rounding
   localparam logic signed [SMSUM_W-1:0] SMOOTH_BIAS = 33'sd1610612739;

   localparam logic signed [WIDE_W-1:0] RATE_MAX = 48'sd134217727;
   localparam logic signed [WIDE_W-1:0] RATE_MIN = -48'sd134217728;

   // register map and reset values
   localparam logic [CSR_INDEX_W-1:0] CSR_CALIB_SAMPLES = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SMOOTH_ENABLE = 8'd1;
   localparam logic [COUNT_W-1:0]     CALIB_RESET       = 16'd100;

   typedef struct packed {
      logic [COUNT_W-1:0] calib_samples;
      logic               smooth_enable;
   } cfg_type;

   // one classified sample: body-frame signed words
   typedef struct packed {
      logic                     calib;
      logic signed [WORD_W-1:0] w_z;
      logic signed [WORD_W-1:0] w_y;
      logic signed [WORD_W-1:0] w_x;
   } entry_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_MUL,
      BK_CORR,
      BK_SMSUM,
      BK_SMDIV,
      BK_ACC,
      BK_DSTART,
      BK_DWAIT,
      BK_OUT
   } back_state_type;

   // clamp to 28 bit signed
   function automatic logic signed [RATE_W-1:0] sat_rate(input logic signed [WIDE_W-1:0] v);
      logic signed [RATE_W-1:0] r;
      if (v > RATE_MAX) begin
         r = RATE_MAX[RATE_W-1:0];
      end else if (v < RATE_MIN) begin
         r = RATE_MIN[RATE_W-1:0];
      end else begin
         r = v[RATE_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* hdl/grbs_front.sv */
// grbs_front: accepts sample transactions and maps chip axes to body axes.
// Depends on grbs_pkg; pushes into grbs_queue.
`default_nettype none

module grbs_front (
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [grbs_pkg::REQ_TDATA_W-1:0] req_tdata,  // raw_chip_x, raw_chip_y, raw_chip_z
   input  wire logic [0:0]                       req_tuser,  // func
   input  wire logic                             q_full,
   output logic                                  q_push,
   output grbs_pkg::entry_type                   q_entry
);
   import grbs_pkg::*;

   logic signed [WORD_W-1:0] chip_x;
   logic signed [WORD_W-1:0] chip_y;
   logic signed [WORD_W-1:0] chip_z;

   // accept whenever the queue has room
   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   // two's complement words, one bit wider so chip Y can be negated
   assign chip_x = WORD_W'($signed(req_tdata[RAW_W-1:0]));
   assign chip_y = WORD_W'($signed(req_tdata[2*RAW_W-1:RAW_W]));
   assign chip_z = WORD_W'($signed(req_tdata[3*RAW_W-1:2*RAW_W]));

   // body X is -chip Y, body Y is chip X, body Z is chip Z
   always_comb begin
      q_entry.calib = req_tuser[0];
      q_entry.w_x   = -chip_y;
      q_entry.w_y   = chip_x;
      q_entry.w_z   = chip_z;
   end

endmodule

`default_nettype wire

/* hdl/grbs_queue.sv */
// grbs_queue: short fifo between the front and back parts.
// Depends on grbs_pkg for the entry type and depth.
`default_nettype none

module grbs_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  grbs_pkg::entry_type      push_entry,
   output logic                     full,
   input  wire logic                pop,
   output logic                     valid,
   output grbs_pkg::entry_type      pop_entry
);
   import grbs_pkg::*;

   entry_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     fill_ff, fill_in;
   logic                do_push;
   logic                do_pop;

   assign full      = (fill_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign valid     = (fill_ff != '0);
   assign pop_entry = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && valid;

   // pointer and fill updates
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

/* hdl/grbs_div.sv */
// grbs_div: restoring unsigned divider, one quotient bit per cycle.
// Depends on grbs_pkg for operand widths; used by grbs_back for the bias.
`default_nettype none

module grbs_div (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [grbs_pkg::DIV_NUM_W-1:0] dividend,
   input  wire logic [grbs_pkg::DIV_DEN_W-1:0] divisor,
   output logic                                done,
   output logic [grbs_pkg::DIV_NUM_W-1:0]      quotient
);
   import grbs_pkg::*;

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [DIV_DEN_W-1:0]    den_ff, den_in;
   logic [DIV_DEN_W-1:0]    rem_ff, rem_in;
   logic [DIV_NUM_W-1:0]    quo_ff, quo_in;
   logic [DIV_DEN_W:0]      trial;
   logic                    fits;

   assign done     = done_ff;
   assign quotient = quo_ff;

   // one shift-subtract step
   assign trial = {rem_ff, quo_ff[DIV_NUM_W-1]};
   assign fits  = (trial >= {1'b0, den_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         den_in  = divisor;
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = fits ? DIV_DEN_W'(trial - {1'b0, den_ff}) : trial[DIV_DEN_W-1:0];
         quo_in = {quo_ff[DIV_NUM_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

endmodule

`default_nettype wire

/* hdl/grbs_back.sv */
// grbs_back: scaling, bias correction, smoothing and calibration sequencer
// with the result register. Depends on grbs_pkg and grbs_div.
`default_nettype none

module grbs_back #(
   parameter int FRAC_BITS = 20
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  grbs_pkg::cfg_type                     cfg,
   input  wire logic                             q_valid,
   input  grbs_pkg::entry_type                   q_entry,
   output logic                                  q_pop,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [grbs_pkg::RSP_TDATA_W-1:0]      rsp_tdata,  // rate_x, rate_y, rate_z, zero pad
   output logic [0:0]                            rsp_tuser   // is_calibrated
);
   import grbs_pkg::*;

   localparam int SHIFT = 32 - FRAC_BITS;
   localparam logic signed [WIDE_W-1:0] HALF   = 48'sd1 <<< (SHIFT - 1);
   localparam logic signed [WIDE_W-1:0] OFFSET = 48'sd1 <<< RATE_W;

   back_state_type state_ff, state_in;

   logic signed [WORD_W-1:0] w_ff    [AXES];
   logic signed [WORD_W-1:0] w_in    [AXES];
   logic                     calib_ff, calib_in;
   logic signed [PROD_W-1:0] prod_ff [AXES];
   logic signed [PROD_W-1:0] prod_in [AXES];
   logic signed [RATE_W-1:0] v_ff    [AXES];
   logic signed [RATE_W-1:0] v_in    [AXES];
   logic [HALF_W-1:0]        half_ff [AXES];
   logic [HALF_W-1:0]        half_in [AXES];
   logic signed [RATE_W-1:0] tap_ff  [AXES][TAP_N];
   logic signed [RATE_W-1:0] tap_in  [AXES][TAP_N];
   logic signed [RATE_W-1:0] bias_ff [AXES];
   logic signed [RATE_W-1:0] bias_in [AXES];
   logic signed [SUM_W-1:0]  sum_ff  [AXES];
   logic signed [SUM_W-1:0]  sum_in  [AXES];
   logic [COUNT_W-1:0]       count_ff, count_in;
   logic                     cal_done_ff, cal_done_in;
   logic [1:0]               axis_ff, axis_in;
   logic                     neg_ff, neg_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                     rsp_user_ff, rsp_user_in;

   logic                     smooth_on;
   logic [COUNT_W-1:0]       need;
   logic [COUNT_W:0]         count_inc;
   logic                     round_end;
   logic                     out_free;
   logic                     div_start;
   logic                     div_done;
   logic [DIV_NUM_W-1:0]     div_num;
   logic [DIV_DEN_W-1:0]     div_den;
   logic [DIV_NUM_W-1:0]     div_quo;
   logic signed [DIV_NUM_W:0] bias_num;
   logic signed [DIV_NUM_W:0] bias_q;

   logic signed [WIDE_W-1:0]    scaled_w [AXES];
   logic signed [WIDE_W-1:0]    corr_w   [AXES];
   logic signed [SMSUM_W-1:0]   smsum    [AXES];
   logic [RECIP_P_W-1:0]        recip_p  [AXES];
   logic signed [WIDE_W-1:0]    smooth_w [AXES];

   assign smooth_on = cal_done_ff && cfg.smooth_enable;
   assign need      = (cfg.calib_samples == '0) ? COUNT_W'(1) : cfg.calib_samples;
   assign count_inc = {1'b0, count_ff} + 1'b1;
   assign round_end = (count_inc >= {1'b0, need});
   assign out_free  = !rsp_valid_ff || rsp_tready;

   // bias = floor((2*sum + n) / (2n)), sign handled around an unsigned divide
   assign bias_num = $signed({sum_ff[axis_ff], 1'b0})
                   + $signed({{(DIV_NUM_W-COUNT_W){1'b0}}, count_ff});
   assign div_num  = bias_num[DIV_NUM_W] ? ~bias_num[DIV_NUM_W-1:0] : bias_num[DIV_NUM_W-1:0];
   assign div_den  = {count_ff, 1'b0};
   assign bias_q   = neg_ff ? ~$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});

   grbs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_quo)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE:   if (q_valid) state_in = BK_MUL;
         BK_MUL:    state_in = BK_CORR;
         BK_CORR:   state_in = smooth_on ? BK_SMSUM : BK_ACC;
         BK_SMSUM:  state_in = BK_SMDIV;
         BK_SMDIV:  state_in = BK_ACC;
         BK_ACC:    state_in = (calib_ff && round_end) ? BK_DSTART : BK_OUT;
         BK_DSTART: state_in = BK_DWAIT;
         BK_DWAIT: begin
            if (div_done) begin
               state_in = (axis_ff == 2'd2) ? BK_OUT : BK_DSTART;
            end
         end
         BK_OUT:    if (out_free) state_in = BK_IDLE;
         default:   state_in = BK_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      q_pop     = 1'b0;
      div_start = 1'b0;
      unique case (state_ff)
         BK_IDLE:   q_pop = q_valid;
         BK_DSTART: div_start = 1'b1;
         default: begin
            q_pop     = 1'b0;
            div_start = 1'b0;
         end
      endcase
   end

   // per-axis arithmetic
   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         scaled_w[i] = (WIDE_W'(prod_ff[i]) + HALF) >>> SHIFT;
         corr_w[i]   = WIDE_W'(sat_rate(scaled_w[i])) - WIDE_W'(bias_ff[i]);
         smsum[i]    = SMSUM_W'(v_ff[i]) + SMSUM_W'(tap_ff[i][0])
                     + ((SMSUM_W'(tap_ff[i][1]) + SMSUM_W'(tap_ff[i][2])) <<< 1)
                     + SMOOTH_BIAS;
         recip_p[i]  = RECIP_P_W'(half_ff[i]) * RECIP_P_W'(RECIP_THIRD);
         smooth_w[i] = $signed(WIDE_W'(recip_p[i][RECIP_P_W-1:32])) - OFFSET;
      end
   end

   // datapath next values
   always_comb begin
      calib_in    = calib_ff;
      count_in    = count_ff;
      cal_done_in = cal_done_ff;
      axis_in     = axis_ff;
      neg_in      = neg_ff;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;
      for (int i = 0; i < AXES; i++) begin
         w_in[i]    = w_ff[i];
         prod_in[i] = prod_ff[i];
         v_in[i]    = v_ff[i];
         half_in[i] = half_ff[i];
         bias_in[i] = bias_ff[i];
         sum_in[i]  = sum_ff[i];
         for (int t = 0; t < TAP_N; t++) begin
            tap_in[i][t] = tap_ff[i][t];
         end
      end

      unique case (state_ff)
         BK_IDLE: begin
            calib_in = q_entry.calib;
            w_in[0]  = q_entry.w_x;
            w_in[1]  = q_entry.w_y;
            w_in[2]  = q_entry.w_z;
         end
         BK_MUL: begin
            for (int i = 0; i < AXES; i++) begin
               prod_in[i] = PROD_W'(w_ff[i]) * PROD_W'(SCALE_Q32);
            end
         end
         BK_CORR: begin
            for (int i = 0; i < AXES; i++) begin
               v_in[i] = sat_rate(corr_w[i]);
            end
         end
         BK_SMSUM: begin
            // newest weight 1, previous weight 1, two oldest weight 2
            for (int i = 0; i < AXES; i++) begin
               half_in[i]   = smsum[i][HALF_W:1];
               tap_in[i][0] = v_ff[i];
               tap_in[i][1] = tap_ff[i][0];
               tap_in[i][2] = tap_ff[i][1];
            end
         end
         BK_SMDIV: begin
            for (int i = 0; i < AXES; i++) begin
               v_in[i] = sat_rate(smooth_w[i]);
            end
         end
         BK_ACC: begin
            axis_in = 2'd0;
            if (calib_ff) begin
               for (int i = 0; i < AXES; i++) begin
                  sum_in[i] = sum_ff[i] + SUM_W'(v_ff[i]);
               end
               count_in = count_inc[COUNT_W-1:0];
            end
         end
         BK_DSTART: begin
            neg_in = bias_num[DIV_NUM_W];
         end
         BK_DWAIT: begin
            if (div_done) begin
               bias_in[axis_ff] = sat_rate(WIDE_W'(bias_q));
               sum_in[axis_ff]  = '0;
               axis_in          = axis_ff + 1'b1;
               if (axis_ff == 2'd2) begin
                  count_in    = '0;
                  cal_done_in = 1'b1;
               end
            end
         end
         BK_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{(RSP_TDATA_W - AXES*RATE_W){1'b0}}, v_ff[2], v_ff[1], v_ff[0]};
               rsp_user_in  = cal_done_ff;
            end
         end
         default: begin
            axis_in = axis_ff;
         end
      endcase
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         count_ff     <= '0;
         cal_done_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < AXES; i++) begin
            bias_ff[i] <= '0;
            sum_ff[i]  <= '0;
            for (int t = 0; t < TAP_N; t++) begin
               tap_ff[i][t] <= '0;
            end
         end
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cal_done_ff  <= cal_done_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < AXES; i++) begin
            bias_ff[i] <= bias_in[i];
            sum_ff[i]  <= sum_in[i];
            for (int t = 0; t < TAP_N; t++) begin
               tap_ff[i][t] <= tap_in[i][t];
            end
         end
      end
   end

   // working payload registers
   always_ff @(posedge clock) begin
      calib_ff    <= calib_in;
      axis_ff     <= axis_in;
      neg_ff      <= neg_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      for (int i = 0; i < AXES; i++) begin
         w_ff[i]    <= w_in[i];
         prod_ff[i] <= prod_in[i];
         v_ff[i]    <= v_in[i];
         half_ff[i] <= half_in[i];
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_user_ff;

endmodule

`default_nettype wire

/* hdl/gyro_rate_bias_smoother.sv */
// gyro_rate_bias_smoother: top level; config registers, front, queue, back.
// Depends on grbs_pkg, grbs_front, grbs_queue, grbs_div and grbs_back.
// Each sample passes the back states IDLE, MUL, CORR, ACC and OUT, plus SMSUM and
// SMDIV with smoothing active; the sample that ends a calibration round also runs
// three bias divisions on the shared one-bit-per-cycle divider.
// The back sequencer handles one sample at a time; the queue in front of it takes more until full.
// Reset (synchronous): clears bias, sums, count, taps and calibrated flag;
// calib_samples returns to 100 and smooth_enable to 1.
`default_nettype none

module gyro_rate_bias_smoother #(
   parameter int FRAC_BITS = 20
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [grbs_pkg::REQ_TDATA_W-1:0]  req_tdata,  // raw_chip_x, raw_chip_y, raw_chip_z
   input  wire logic [0:0]                        req_tuser,  // func
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [grbs_pkg::RSP_TDATA_W-1:0]       rsp_tdata,  // rate_x, rate_y, rate_z, zero pad
   output logic [0:0]                             rsp_tuser,  // is_calibrated
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [grbs_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [grbs_pkg::CSR_DATA_W-1:0]   csr_data
);
   import grbs_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       q_full;
   logic       q_push;
   entry_type  push_entry;
   logic       q_pop;
   logic       q_valid;
   entry_type  pop_entry;

   // register writes, always ready
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_CALIB_SAMPLES: cfg_in.calib_samples = csr_data[COUNT_W-1:0];
            CSR_SMOOTH_ENABLE: cfg_in.smooth_enable = csr_data[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.calib_samples <= CALIB_RESET;
         cfg_ff.smooth_enable <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   grbs_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (push_entry)
   );

   grbs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .valid      (q_valid),
      .pop_entry  (pop_entry)
   );

   grbs_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_entry    (pop_entry),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// tb_top: self-checking bench for the gyro rate bias smoother; drives raw
// samples and config writes, predicts body rates in step with the stream.
// Depends on grbs_pkg and the gyro_rate_bias_smoother RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import grbs_pkg::*;

   localparam int     SHIFT        = 32 - 20;
   localparam longint SCALE_Q       = 5214701;
   localparam longint RATE_HI       = 134217727;
   localparam longint RATE_LO       = -134217728;
   localparam int     SETTLE_CYCLES = 200;
   localparam int     PHASE_ITEMS   = 106;
   localparam int     MAX_REPORTS   = 10;

   typedef struct {
      bit          calib;
      logic [15:0] chip_x;
      logic [15:0] chip_y;
      logic [15:0] chip_z;
   } gyro_sample_type;

   typedef struct packed {
      logic                     calibrated;
      logic signed [RATE_W-1:0] z;
      logic signed [RATE_W-1:0] y;
      logic signed [RATE_W-1:0] x;
   } body_rate_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [0:0]             req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [0:0]             rsp_tuser;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   gyro_rate_bias_smoother uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   // stimulus and scoreboard storage
   gyro_sample_type pending_samples[$];
   body_rate_type   expected_rates[$];
   gyro_sample_type cur_sample;
   int           samples_queued = 0;
   int           samples_accepted = 0;
   int           fault_count = 0;
   int           send_idle_pct = 0;
   int           stall_pct = 0;

   // predictor state and config copy
   longint       tap_ring[3][4];
   int unsigned  tap_pos;
   longint       axis_bias[3];
   longint       bias_acc[3];
   int unsigned  cal_count;
   bit           cal_done;
   int unsigned  cfg_calib_samples;
   bit           cfg_smooth;

   initial begin : predictor_init
      int i;
      int j;
      for (i = 0; i < 3; i++) begin
         for (j = 0; j < 4; j++) begin
            tap_ring[i][j] = 0;
         end
         axis_bias[i] = 0;
         bias_acc[i] = 0;
      end
      tap_pos = 0;
      cal_count = 0;
      cal_done = 1'b0;
      cfg_calib_samples = 100;
      cfg_smooth = 1'b1;
   end

   function automatic longint div_floor(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) begin
         q = q - 1;
      end
      return q;
   endfunction

   function automatic longint clamp_rate(longint v);
      if (v > RATE_HI) begin
         return RATE_HI;
      end
      if (v < RATE_LO) begin
         return RATE_LO;
      end
      return v;
   endfunction

   // raw word to rad/s in Q20, round half up
   function automatic longint word_to_rads(logic [15:0] raw, bit negate);
      longint w;
      w = longint'($signed(raw));
      if (negate) begin
         w = -w;
      end
      return (w * SCALE_Q + (longint'(1) <<< (SHIFT - 1))) >>> SHIFT;
   endfunction

   // advance the predictor by one accepted sample and queue its rate
   function automatic void predict_body_rate(gyro_sample_type s);
      longint        v[3];
      longint        acc;
      longint        n;
      int unsigned   p;
      int unsigned   need;
      int            i;
      body_rate_type r;
      v[0] = clamp_rate(clamp_rate(word_to_rads(s.chip_y, 1'b1)) - axis_bias[0]);
      v[1] = clamp_rate(clamp_rate(word_to_rads(s.chip_x, 1'b0)) - axis_bias[1]);
      v[2] = clamp_rate(clamp_rate(word_to_rads(s.chip_z, 1'b0)) - axis_bias[2]);
      // 1,2,2,1 weighted smoothing once calibrated
      if (cal_done && cfg_smooth) begin
         p = tap_pos;
         for (i = 0; i < 3; i++) begin
            tap_ring[i][p] = v[i];
            acc = tap_ring[i][p] + 2 * tap_ring[i][(p + 1) % 4]
                + 2 * tap_ring[i][(p + 2) % 4] + tap_ring[i][(p + 3) % 4];
            v[i] = clamp_rate(div_floor(acc + 3, 6));
         end
         tap_pos = (p + 1) % 4;
      end
      // bias accumulation and rounded average at the end of a round
      if (s.calib) begin
         need = (cfg_calib_samples == 0) ? 1 : cfg_calib_samples;
         for (i = 0; i < 3; i++) begin
            bias_acc[i] += v[i];
         end
         cal_count++;
         if (cal_count >= need) begin
            n = longint'(cal_count);
            for (i = 0; i < 3; i++) begin
               axis_bias[i] = clamp_rate(div_floor(2 * bias_acc[i] + n, 2 * n));
               bias_acc[i] = 0;
            end
            cal_count = 0;
            cal_done = 1'b1;
         end
      end
      r.x = v[0][RATE_W-1:0];
      r.y = v[1][RATE_W-1:0];
      r.z = v[2][RATE_W-1:0];
      r.calibrated = cal_done;
      expected_rates.push_back(r);
   endfunction

   function automatic void report_fault(string what);
      fault_count++;
      if (fault_count <= MAX_REPORTS) begin
         $display("%0t: %s", $realtime, what);
      end
   endfunction

   // sample driver
   always @(posedge clock) begin : sample_driver
      logic fire;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         fire = req_tvalid && req_tready;
         if (fire) begin
            predict_body_rate(cur_sample);
            samples_accepted++;
         end
         if (!req_tvalid || fire) begin
            if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               cur_sample = pending_samples.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {cur_sample.chip_z, cur_sample.chip_y, cur_sample.chip_x};
               req_tuser  <= cur_sample.calib;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor and checker
   always @(posedge clock) begin : rate_monitor
      body_rate_type got;
      body_rate_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
         if (rsp_tvalid && rsp_tready) begin
            got.x = rsp_tdata[RATE_W-1:0];
            got.y = rsp_tdata[2*RATE_W-1:RATE_W];
            got.z = rsp_tdata[3*RATE_W-1:2*RATE_W];
            got.calibrated = rsp_tuser[0];
            if (expected_rates.size() == 0) begin
               report_fault($sformatf("unexpected rate transaction x=%0d y=%0d z=%0d cal=%0b",
                                      got.x, got.y, got.z, got.calibrated));
            end else begin
               want = expected_rates.pop_front();
               if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
                   got.calibrated !== want.calibrated) begin
                  report_fault($sformatf(
                     "rate mismatch exp x=%0d y=%0d z=%0d cal=%0b got x=%0d y=%0d z=%0d cal=%0b",
                     want.x, want.y, want.z, want.calibrated,
                     got.x, got.y, got.z, got.calibrated));
               end
            end
         end
      end
   end

   task automatic push_sample(input bit calib, input logic [15:0] cx,
                              input logic [15:0] cy, input logic [15:0] cz);
      gyro_sample_type s;
      s.calib  = calib;
      s.chip_x = cx;
      s.chip_y = cy;
      s.chip_z = cz;
      pending_samples.push_back(s);
      samples_queued++;
   endtask

   // register write, only issued while the block is idle
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_CALIB_SAMPLES) begin
         cfg_calib_samples = val;
      end else if (idx == CSR_SMOOTH_ENABLE) begin
         cfg_smooth = val[0];
      end
   endtask

   // hold off until every sample is accepted and every rate is back
   task automatic drain_results();
      while (samples_accepted != samples_queued || expected_rates.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // mostly near a center value, some full-range and boundary words
   function automatic logic [15:0] pick_word(int center);
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) begin
         return 16'($urandom_range(0, 65535));
      end
      if (r < 22) begin
         case ($urandom_range(0, 4))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'h0001;
         endcase
      end
      return 16'(center + int'($urandom_range(0, 16)) - 8);
   endfunction

   function automatic int pick_center();
      if ($urandom_range(0, 4) == 0) begin
         return int'($urandom_range(0, 65535));
      end
      return int'($urandom_range(0, 600)) - 300;
   endfunction

   // random calibration bursts and measurement runs
   task automatic fill_phase(input int unsigned cal_setting, input int total);
      int          left;
      int          len;
      int          k;
      int          cx;
      int          cy;
      int          cz;
      bit          calib;
      int unsigned need;
      left = total;
      need = (cal_setting == 0) ? 1 : cal_setting;
      while (left > 0) begin
         cx = pick_center();
         cy = pick_center();
         cz = pick_center();
         calib = ($urandom_range(0, 99) < 40);
         if (calib) begin
            if (need <= 6 && $urandom_range(0, 4) != 0) begin
               len = need;
            end else begin
               len = $urandom_range(1, 6);
            end
         end else begin
            len = $urandom_range(1, 10);
         end
         for (k = 0; k < len && left > 0; k++) begin
            push_sample(calib, pick_word(cx), pick_word(cy), pick_word(cz));
            left--;
         end
      end
   endtask

   initial begin : stimulus
      int unsigned cal_plan[8];
      bit          smooth_plan[8];
      int          ph;
      cal_plan    = '{1, 5, 65535, 2, 0, 8, 3, 100};
      smooth_plan = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes before calibration, a short round, smoothed extremes
      write_csr(CSR_CALIB_SAMPLES, 16'd3);
      write_csr(CSR_SMOOTH_ENABLE, 16'd1);
      push_sample(1'b0, 16'h0000, 16'h0000, 16'h0000);
      push_sample(1'b0, 16'h7FFF, 16'h8000, 16'h7FFF);
      push_sample(1'b0, 16'h8000, 16'h7FFF, 16'h8000);
      push_sample(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      push_sample(1'b0, 16'h0001, 16'h0001, 16'h0001);
      push_sample(1'b0, 16'h5A5A, 16'hA5A5, 16'h0F0F);
      push_sample(1'b1, 16'h0040, 16'hFFC0, 16'h0010);
      push_sample(1'b1, 16'h0042, 16'hFFBE, 16'h0012);
      push_sample(1'b1, 16'h0041, 16'hFFBF, 16'h0011);
      push_sample(1'b0, 16'h8000, 16'h7FFF, 16'h8000);
      push_sample(1'b0, 16'h7FFF, 16'h8000, 16'h7FFF);
      push_sample(1'b0, 16'h0000, 16'h0000, 16'h0000);
      push_sample(1'b0, 16'h0041, 16'hFFBF, 16'h0011);
      push_sample(1'b0, 16'hFFFF, 16'h0001, 16'hFFFF);
      push_sample(1'b0, 16'hA5A5, 16'h5A5A, 16'hF0F0);
      push_sample(1'b0, 16'h0003, 16'hFFFD, 16'h0007);
      // recalibration while smoothing is active
      push_sample(1'b1, 16'h0010, 16'hFFF0, 16'h0020);
      push_sample(1'b1, 16'h0011, 16'hFFF1, 16'h0021);
      push_sample(1'b1, 16'h000F, 16'hFFEF, 16'h001F);
      push_sample(1'b0, 16'h0010, 16'hFFF0, 16'h0020);
      push_sample(1'b0, 16'h7FFF, 16'h8000, 16'h7FFF);
      drain_results();

      // random phases; a huge sample count carries sums into the next phase
      for (ph = 0; ph < 8; ph++) begin
         write_csr(CSR_CALIB_SAMPLES, cal_plan[ph][15:0]);
         write_csr(CSR_SMOOTH_ENABLE, {15'd0, smooth_plan[ph]});
         case (ph % 4)
            0: begin
               send_idle_pct <= 0;
               stall_pct     <= 0;
            end
            1: begin
               send_idle_pct <= 66;
               stall_pct     <= 0;
            end
            2: begin
               send_idle_pct <= 0;
               stall_pct     <= 66;
            end
            default: begin
               send_idle_pct <= 14;
               stall_pct     <= 14;
            end
         endcase
         fill_phase(cal_plan[ph], PHASE_ITEMS);
         drain_results();
      end

      if (fault_count == 0 && expected_rates.size() == 0) begin
         $display("PASS gyro_rate_bias_smoother");
      end else begin
         $display("FAIL gyro_rate_bias_smoother");
      end
      $finish;
   end

   // run limit
   initial begin : watchdog
      #(4_000_000);
      $display("FAIL gyro_rate_bias_smoother");
      $finish;
   end

endmodule

/* sim.f */
hdl/grbs_pkg.sv
hdl/grbs_front.sv
hdl/grbs_queue.sv
hdl/grbs_div.sv
hdl/grbs_back.sv
hdl/gyro_rate_bias_smoother.sv
verif/tb_top.sv
